// File: hdl/rld_pkg.sv
package rld_pkg;

    // Field widths fixed by the transaction formats
    localparam int CHANNEL_W = 3;
    localparam int RSSI_W    = 10;
    localparam int TIME_W    = 32;
    localparam int LEVEL_W   = 10;
    localparam int COUNT_W   = 8;
    localparam int THR_W     = 10;
    localparam int LOCKOUT_W = 16;

    // Largest value the average_level field can carry
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

    // Default structural parameters
    localparam int CHANNELS_DEF    = 8;
    localparam int WINDOW_DEF      = 8;
    localparam int SAMPLE_BITS_DEF = 10;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_COUNT = 2'd2;

    localparam logic [THR_W-1:0]     THRESHOLD_RST = 10'd215;
    localparam logic [LOCKOUT_W-1:0] LOCKOUT_RST   = 16'd3000;
    localparam logic [COUNT_W-1:0]   MIN_COUNT_RST = 8'd3;

    typedef struct packed {
        logic [THR_W-1:0]     threshold;
        logic [LOCKOUT_W-1:0] lockout;
        logic [COUNT_W-1:0]   min_count;
    } cfg_t;

endpackage

// File: hdl/rld_if.sv
// Sample transaction: one raw RSSI reading for a channel
interface rld_sample_if;
    logic                            valid;
    logic                            ready;
    logic [rld_pkg::CHANNEL_W-1:0]   channel;
    logic [rld_pkg::RSSI_W-1:0]      rssi_sample;
    logic [rld_pkg::TIME_W-1:0]      now_ms;

    modport source (output valid, channel, rssi_sample, now_ms, input ready);
    modport sink   (input valid, channel, rssi_sample, now_ms, output ready);
endinterface

// Result transaction: lap flag and updated average
interface rld_result_if;
    logic                            valid;
    logic                            ready;
    logic                            lap_event;
    logic [rld_pkg::CHANNEL_W-1:0]   lap_channel;
    logic [rld_pkg::LEVEL_W-1:0]     average_level;

    modport source (output valid, lap_event, lap_channel, average_level, input ready);
    modport sink   (input valid, lap_event, lap_channel, average_level, output ready);
endinterface

// Register write transaction
interface rld_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [rld_pkg::CFG_IDX_W-1:0]   reg_index;
    logic [rld_pkg::CFG_DATA_W-1:0]  reg_data;

    modport source (output valid, reg_index, reg_data, input ready);
    modport sink   (input valid, reg_index, reg_data, output ready);
endinterface

// File: hdl/rssi_lap_detector_top.sv
// Each accepted sample passes the stage 1, stage 2 and result registers before its result is valid.
// Throughput: one sample per clock unless results stall; the registered reads of the per-channel
// state memory and then the sample ring memory set the three-register pipeline depth.
// Reset: configuration returns to defaults, the pipeline empties, and per-channel valid
// bits clear so every channel state and ring reads as zero; no clearing pass is needed.
module rssi_lap_detector_top #(
    parameter int CHANNELS    = rld_pkg::CHANNELS_DEF,
    parameter int WINDOW      = rld_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = rld_pkg::SAMPLE_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    rld_cfg_if.sink      cfg,
    rld_sample_if.sink   samples,
    rld_result_if.source results
);

    localparam int CH_AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int POS_W     = $clog2(WINDOW);
    localparam int TOT_W     = SAMPLE_BITS + POS_W;
    localparam int SMP_AW    = CH_AW + POS_W;
    localparam int SMP_DEPTH = CHANNELS << POS_W;
    localparam int RSSI_XW   = (SAMPLE_BITS > rld_pkg::RSSI_W) ? SAMPLE_BITS : rld_pkg::RSSI_W;

    typedef struct packed {
        logic [TOT_W-1:0]             total;
        logic [POS_W-1:0]             pos;
        logic                         filled;
        logic                         active;
        logic [rld_pkg::COUNT_W-1:0]  count;
        logic [rld_pkg::TIME_W-1:0]   deadline;
    } chan_state_t;

    // Configuration registers
    rld_pkg::cfg_t cfg_reg;

    // Stage 1: accepted sample, state memory read data
    logic                           s1_vld_reg;
    logic [rld_pkg::CHANNEL_W-1:0]  s1_ch_reg;
    logic                           s1_inr_reg;
    logic [SAMPLE_BITS-1:0]         s1_smp_reg;
    logic [rld_pkg::TIME_W-1:0]     s1_now_reg;
    chan_state_t                    st_rd_reg;
    logic                           st_rd_vld_reg;
    logic                           fwd_hit_reg;
    chan_state_t                    fwd_st_reg;

    // Stage 2: resolved state, sample memory read data
    logic                           s2_vld_reg;
    logic [rld_pkg::CHANNEL_W-1:0]  s2_ch_reg;
    logic                           s2_inr_reg;
    logic [SAMPLE_BITS-1:0]         s2_smp_reg;
    logic [rld_pkg::TIME_W-1:0]     s2_now_reg;
    chan_state_t                    st2_reg;
    logic [SAMPLE_BITS-1:0]         smp_rd_reg;

    // Result register
    logic                           out_vld_reg;
    logic                           out_lap_reg;
    logic [rld_pkg::CHANNEL_W-1:0]  out_ch_reg;
    logic [rld_pkg::LEVEL_W-1:0]    out_avg_reg;

    // Memories and per-channel valid bits
    chan_state_t                    st_mem [CHANNELS];
    logic [SAMPLE_BITS-1:0]         smp_mem [SMP_DEPTH];
    logic [CHANNELS-1:0]            st_vld_reg;

    logic                           accept;
    logic                           s1_adv;
    logic                           s2_adv;
    logic                           wr_en;
    logic                           in_range;
    logic [CH_AW-1:0]               in_idx;
    logic [CH_AW-1:0]               s1_idx;
    logic [CH_AW-1:0]               s2_idx;
    logic [RSSI_XW-1:0]             rssi_ext;
    logic [SAMPLE_BITS-1:0]         in_smp;
    chan_state_t                    st_cur;
    chan_state_t                    st_next;
    logic                           lap;
    logic [rld_pkg::LEVEL_W-1:0]    avg_level;

    // Handshake and pipeline advance
    assign s2_adv        = s2_vld_reg && (!out_vld_reg || results.ready);
    assign s1_adv        = s1_vld_reg && (!s2_vld_reg || s2_adv);
    assign samples.ready = !s1_vld_reg || s1_adv;
    assign accept        = samples.valid && samples.ready;
    assign wr_en         = s2_adv && s2_inr_reg;
    assign cfg.ready     = 1'b1;

    // Channel decode and sample masking
    assign in_range = ({29'd0, samples.channel} < 32'(CHANNELS));
    assign in_idx   = CH_AW'(samples.channel);
    assign s1_idx   = CH_AW'(s1_ch_reg);
    assign s2_idx   = CH_AW'(s2_ch_reg);
    assign rssi_ext = RSSI_XW'(samples.rssi_sample);
    assign in_smp   = rssi_ext[SAMPLE_BITS-1:0];

    // State bypass: the item ahead in stage 2, then the write that met the read
    always_comb
    begin
        if (s2_vld_reg && s2_inr_reg && (s2_idx == s1_idx))
        begin
            st_cur = st_next;
        end
        else if (fwd_hit_reg)
        begin
            st_cur = fwd_st_reg;
        end
        else if (st_rd_vld_reg)
        begin
            st_cur = st_rd_reg;
        end
        else
        begin
            st_cur = '0;
        end
    end

    rld_gate_logic #(
        .WINDOW       (WINDOW),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .chan_state_t (chan_state_t)
    ) u_gate (
        .st        (st2_reg),
        .old_smp   (smp_rd_reg),
        .smp       (s2_smp_reg),
        .now_ms    (s2_now_reg),
        .cfg       (cfg_reg),
        .st_next   (st_next),
        .lap       (lap),
        .avg_level (avg_level)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold <= rld_pkg::THRESHOLD_RST;
            cfg_reg.lockout   <= rld_pkg::LOCKOUT_RST;
            cfg_reg.min_count <= rld_pkg::MIN_COUNT_RST;
            s1_vld_reg        <= 1'b0;
            s2_vld_reg        <= 1'b0;
            out_vld_reg       <= 1'b0;
            st_vld_reg        <= '0;
            st_rd_vld_reg     <= 1'b0;
            fwd_hit_reg       <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.reg_index)
                    rld_pkg::REG_THRESHOLD:
                        cfg_reg.threshold <= cfg.reg_data[rld_pkg::THR_W-1:0];
                    rld_pkg::REG_LOCKOUT:
                        cfg_reg.lockout   <= cfg.reg_data[rld_pkg::LOCKOUT_W-1:0];
                    rld_pkg::REG_MIN_COUNT:
                        cfg_reg.min_count <= cfg.reg_data[rld_pkg::COUNT_W-1:0];
                    default:
                        ;
                endcase
            end

            if (accept)
            begin
                s1_vld_reg    <= 1'b1;
                st_rd_vld_reg <= st_vld_reg[in_idx];
                fwd_hit_reg   <= wr_en && (s2_idx == in_idx);
            end
            else if (s1_adv)
            begin
                s1_vld_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                s2_vld_reg <= 1'b1;
            end
            else if (s2_adv)
            begin
                s2_vld_reg <= 1'b0;
            end

            if (s2_adv)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_vld_reg <= 1'b0;
            end

            if (wr_en)
            begin
                st_vld_reg[s2_idx] <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ch_reg  <= samples.channel;
            s1_inr_reg <= in_range;
            s1_smp_reg <= in_smp;
            s1_now_reg <= samples.now_ms;
            fwd_st_reg <= st_next;
        end
        if (s1_adv)
        begin
            s2_ch_reg  <= s1_ch_reg;
            s2_inr_reg <= s1_inr_reg;
            s2_smp_reg <= s1_smp_reg;
            s2_now_reg <= s1_now_reg;
            st2_reg    <= st_cur;
        end
        if (s2_adv)
        begin
            out_lap_reg <= s2_inr_reg && lap;
            out_ch_reg  <= s2_ch_reg;
            out_avg_reg <= s2_inr_reg ? avg_level : '0;
        end
    end

    // Per-channel state memory
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            st_rd_reg <= st_mem[in_idx];
        end
        if (wr_en)
        begin
            st_mem[s2_idx] <= st_next;
        end
    end

    // Sample ring memory
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            smp_rd_reg <= smp_mem[SMP_AW'({s1_idx, st_cur.pos})];
        end
        if (wr_en)
        begin
            smp_mem[SMP_AW'({s2_idx, st2_reg.pos})] <= s2_smp_reg;
        end
    end

    assign results.valid         = out_vld_reg;
    assign results.lap_event     = out_lap_reg;
    assign results.lap_channel   = out_ch_reg;
    assign results.average_level = out_avg_reg;

    // Unknown channels never report a lap and give a zero average
    a_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && ({29'd0, results.lap_channel} >= 32'(CHANNELS))
        |-> !results.lap_event && (results.average_level == '0))
        else $error("out-of-range channel produced a non-zero result");

    // An accepted sample occupies stage 1 on the next cycle
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_vld_reg)
        else $error("accepted sample lost at stage 1");

    // A state write marks its channel valid
    a_write_valid: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> st_vld_reg[$past(s2_idx)])
        else $error("channel valid bit not set after state write");

endmodule

// File: hdl/rld_gate_logic.sv
// Per-channel update: moving average and crossing/lap decision
module rld_gate_logic #(
    parameter int  WINDOW       = rld_pkg::WINDOW_DEF,
    parameter int  SAMPLE_BITS  = rld_pkg::SAMPLE_BITS_DEF,
    parameter type chan_state_t = logic
) (
    input  chan_state_t                    st,
    input  logic [SAMPLE_BITS-1:0]         old_smp,
    input  logic [SAMPLE_BITS-1:0]         smp,
    input  logic [rld_pkg::TIME_W-1:0]     now_ms,
    input  rld_pkg::cfg_t                  cfg,
    output chan_state_t                    st_next,
    output logic                           lap,
    output logic [rld_pkg::LEVEL_W-1:0]    avg_level
);

    localparam int POS_W = $clog2(WINDOW);
    localparam int TOT_W = SAMPLE_BITS + POS_W;
    localparam int CMP_W = (SAMPLE_BITS > rld_pkg::THR_W) ? SAMPLE_BITS : rld_pkg::THR_W;

    // total / WINDOW as multiply by rounded-up reciprocal, exact for TOT_W-bit totals
    localparam int RECIP_SHIFT = TOT_W + POS_W;
    localparam int RECIP_W     = TOT_W + 1;
    localparam int PROD_W      = TOT_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
        ((longint'(1) << RECIP_SHIFT) + longint'(WINDOW) - longint'(1)) / longint'(WINDOW));

    logic [SAMPLE_BITS-1:0] old_val;
    logic [TOT_W-1:0]       total;
    logic [PROD_W-1:0]      prod;
    logic [SAMPLE_BITS-1:0] avg;
    logic [CMP_W-1:0]       avg_ext;
    logic                   above;
    logic                   wrap;

    // Running total and average
    always_comb
    begin
        old_val = st.filled ? old_smp : '0;
        total   = st.total - TOT_W'(old_val) + TOT_W'(smp);
        prod    = PROD_W'(total) * PROD_W'(RECIP);
        avg     = prod[RECIP_SHIFT +: SAMPLE_BITS];
        avg_ext = CMP_W'(avg);
        above   = avg_ext >= CMP_W'(cfg.threshold);
        wrap    = (st.pos == POS_W'(WINDOW - 1));
    end

    // Crossing state machine per channel
    always_comb
    begin
        st_next        = st;
        st_next.total  = total;
        st_next.pos    = wrap ? '0 : st.pos + POS_W'(1);
        st_next.filled = st.filled | wrap;
        lap            = 1'b0;
        if (st.active)
        begin
            if (!above)
            begin
                st_next.active = 1'b0;
                if (st.count >= cfg.min_count)
                begin
                    st_next.deadline = now_ms + rld_pkg::TIME_W'(cfg.lockout);
                    lap              = 1'b1;
                end
            end
            else if (st.count != '1)
            begin
                st_next.count = st.count + rld_pkg::COUNT_W'(1);
            end
        end
        else if ((st.deadline < now_ms) && above)
        begin
            st_next.count  = '0;
            st_next.active = 1'b1;
        end
    end

    // Saturate to the result field
    assign avg_level = (avg_ext > CMP_W'(rld_pkg::LEVEL_MAX)) ? rld_pkg::LEVEL_MAX
                                                              : avg_ext[rld_pkg::LEVEL_W-1:0];

endmodule

// File: verif/rssi_lap_detector_checker.sv
// Watches the register, sample and result channels, predicts each result from
// the accepted samples and compares it against what the block returns.
module rssi_lap_detector_checker #(
    parameter int CHANNELS = rld_pkg::CHANNELS_DEF,
    parameter int WINDOW   = rld_pkg::WINDOW_DEF
) (
    input  logic   clk,
    input  logic   rst_n,
    rld_cfg_if     cfg,
    rld_sample_if  samples,
    rld_result_if  results,
    output int     error_count,
    output int     pending_count
);

    typedef struct packed {
        logic                          lap_event;
        logic [rld_pkg::CHANNEL_W-1:0] lap_channel;
        logic [rld_pkg::LEVEL_W-1:0]   average_level;
    } gate_result_t;

    // Shadow of the configuration registers
    rld_pkg::cfg_t cfg_shadow;

    // Per-channel gate state
    logic [rld_pkg::RSSI_W-1:0]  ring_mem [CHANNELS][WINDOW];
    int unsigned                 ring_sum [CHANNELS];
    int unsigned                 ring_slot [CHANNELS];
    logic                        crossing_on [CHANNELS];
    logic [rld_pkg::COUNT_W-1:0] above_cnt [CHANNELS];
    logic [rld_pkg::TIME_W-1:0]  lockout_end [CHANNELS];

    // Results predicted but not yet returned, oldest first
    gate_result_t pending_gate_results [$];

    task automatic flag_error(input string msg);
        $display("%0t checker: %s", $time, msg);
        error_count++;
    endtask

    // Moving average update and crossing / lap decision for one sample
    function automatic gate_result_t gate_update(input logic [rld_pkg::CHANNEL_W-1:0] ch,
                                                 input logic [rld_pkg::RSSI_W-1:0]    raw,
                                                 input logic [rld_pkg::TIME_W-1:0]    now);
        gate_result_t res;
        int unsigned  slot;
        int unsigned  avg;
        res = '0;
        res.lap_channel = ch;
        if (ch >= CHANNELS)
            return res;

        slot = ring_slot[ch];
        ring_sum[ch] = ring_sum[ch] - ring_mem[ch][slot] + raw;
        ring_mem[ch][slot] = raw;
        ring_slot[ch] = (slot + 1 >= WINDOW) ? 0 : slot + 1;
        avg = ring_sum[ch] / WINDOW;

        if (crossing_on[ch])
        begin
            if (avg < cfg_shadow.threshold)
            begin
                crossing_on[ch] = 1'b0;
                if (above_cnt[ch] >= cfg_shadow.min_count)
                begin
                    // deadline wraps modulo 2^32
                    lockout_end[ch] = now + cfg_shadow.lockout;
                    res.lap_event = 1'b1;
                end
            end
            else if (above_cnt[ch] != '1)
            begin
                above_cnt[ch]++;
            end
        end
        else if (lockout_end[ch] < now && avg >= cfg_shadow.threshold)
        begin
            above_cnt[ch] = '0;
            crossing_on[ch] = 1'b1;
        end

        res.average_level = (avg > rld_pkg::LEVEL_MAX) ? rld_pkg::LEVEL_MAX
                                                       : avg[rld_pkg::LEVEL_W-1:0];
        return res;
    endfunction

    // Channel monitor: results are checked before this edge's sample is queued
    always @(posedge clk or negedge rst_n)
    begin : monitor
        gate_result_t got;
        gate_result_t want;
        if (!rst_n)
        begin
            cfg_shadow.threshold = rld_pkg::THRESHOLD_RST;
            cfg_shadow.lockout   = rld_pkg::LOCKOUT_RST;
            cfg_shadow.min_count = rld_pkg::MIN_COUNT_RST;
            for (int c = 0; c < CHANNELS; c++)
            begin
                ring_sum[c]    = 0;
                ring_slot[c]   = 0;
                crossing_on[c] = 1'b0;
                above_cnt[c]   = '0;
                lockout_end[c] = '0;
                for (int s = 0; s < WINDOW; s++)
                    ring_mem[c][s] = '0;
            end
            pending_gate_results.delete();
            pending_count <= 0;
        end
        else
        begin
            if (results.valid && results.ready)
            begin
                got = '{results.lap_event, results.lap_channel, results.average_level};
                if (pending_gate_results.size() == 0)
                begin
                    flag_error($sformatf("unexpected result ch %0d level %0d lap %0b",
                                         got.lap_channel, got.average_level, got.lap_event));
                end
                else
                begin
                    want = pending_gate_results.pop_front();
                    if (got.lap_channel !== want.lap_channel)
                        flag_error($sformatf("lap_channel got %0d want %0d",
                                             got.lap_channel, want.lap_channel));
                    if (got.average_level !== want.average_level)
                        flag_error($sformatf("ch %0d average_level got %0d want %0d",
                                             want.lap_channel, got.average_level,
                                             want.average_level));
                    if (got.lap_event !== want.lap_event)
                        flag_error($sformatf("ch %0d lap_event got %0b want %0b",
                                             want.lap_channel, got.lap_event,
                                             want.lap_event));
                end
            end

            // register writes; an unknown index changes nothing
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.reg_index)
                    rld_pkg::REG_THRESHOLD:
                        cfg_shadow.threshold = cfg.reg_data[rld_pkg::THR_W-1:0];
                    rld_pkg::REG_LOCKOUT:
                        cfg_shadow.lockout   = cfg.reg_data[rld_pkg::LOCKOUT_W-1:0];
                    rld_pkg::REG_MIN_COUNT:
                        cfg_shadow.min_count = cfg.reg_data[rld_pkg::COUNT_W-1:0];
                    default:
                        ;
                endcase
            end

            if (samples.valid && samples.ready)
                pending_gate_results.push_back(gate_update(samples.channel,
                                                           samples.rssi_sample,
                                                           samples.now_ms));

            pending_count <= pending_gate_results.size();
        end
    end

endmodule

// File: verif/rssi_lap_detector_top_tb.sv
module rssi_lap_detector_top_tb;

    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 330;
    localparam int IDLE_PCT     = 28;
    localparam int SETTLE_CYCLES = 4;
    localparam int RSSI_MAX     = (1 << rld_pkg::RSSI_W) - 1;
    localparam int CHANNEL_MAX  = (1 << rld_pkg::CHANNEL_W) - 1;

    // index with no register behind it
    localparam logic [rld_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef logic [rld_pkg::CHANNEL_W-1:0]  chan_t;
    typedef logic [rld_pkg::RSSI_W-1:0]     level_t;
    typedef logic [rld_pkg::CFG_DATA_W-1:0] reg_data_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // no idling on either side while set
    logic steady = 1'b0;

    int                          sent = 0;
    int                          mismatches;
    int                          outstanding;
    logic [rld_pkg::THR_W-1:0]   threshold_now = rld_pkg::THRESHOLD_RST;
    logic [rld_pkg::TIME_W-1:0]  clock_ms = '0;

    rld_cfg_if    cfg_ch ();
    rld_sample_if sample_ch ();
    rld_result_if result_ch ();

    rssi_lap_detector_top u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .samples (sample_ch),
        .results (result_ch)
    );

    rssi_lap_detector_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_ch),
        .samples       (sample_ch),
        .results       (result_ch),
        .error_count   (mismatches),
        .pending_count (outstanding)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Result backpressure
    always @(posedge clk)
    begin
        result_ch.ready <= rst_n && (steady || $urandom_range(0, 99) >= IDLE_PCT);
    end

    // One sample transaction; each cycle in front of it idles at random
    task automatic put_sample(input chan_t                      ch,
                              input level_t                     level,
                              input logic [rld_pkg::TIME_W-1:0] now);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid       <= 1'b1;
        sample_ch.channel     <= ch;
        sample_ch.rssi_sample <= level;
        sample_ch.now_ms      <= now;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic write_reg(input logic [rld_pkg::CFG_IDX_W-1:0] idx,
                             input reg_data_t                     data);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.reg_data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        if (idx == rld_pkg::REG_THRESHOLD)
            threshold_now = data[rld_pkg::THR_W-1:0];
        @(posedge clk);
    endtask

    // Hold off new samples until every predicted result has been returned
    task automatic drain_results;
        sample_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // Rise above the threshold then fall below it, random levels and spacing
    task automatic run_crossing(input chan_t ch,
                                input int n_high,
                                input int n_low);
        int low_max;
        low_max = (threshold_now == 0) ? 0 : threshold_now - 1;
        repeat (n_high)
        begin
            clock_ms += $urandom_range(0, 200);
            put_sample(ch, level_t'($urandom_range(threshold_now, RSSI_MAX)), clock_ms);
        end
        repeat (n_low)
        begin
            clock_ms += $urandom_range(0, 200);
            put_sample(ch, level_t'($urandom_range(0, low_max)), clock_ms);
        end
    endtask

    // Mostly crossing sequences on the given channels, some fully random samples
    task automatic run_phase(input int items, input int noise_pct,
                             input int ch_lo, input int ch_hi);
        int stop_at;
        stop_at = sent + items;
        while (sent < stop_at)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                put_sample(chan_t'($urandom_range(0, CHANNEL_MAX)),
                           level_t'($urandom_range(0, RSSI_MAX)), $urandom());
            else
                run_crossing(chan_t'($urandom_range(ch_lo, ch_hi)), $urandom_range(1, 14),
                             $urandom_range(1, 12));
        end
        drain_results();
    endtask

    // Stimulus
    initial
    begin : stimulus
        int k;
        cfg_ch.valid          = 1'b0;
        cfg_ch.reg_index      = rld_pkg::REG_THRESHOLD;
        cfg_ch.reg_data       = '0;
        sample_ch.valid       = 1'b0;
        sample_ch.channel     = '0;
        sample_ch.rssi_sample = '0;
        sample_ch.now_ms      = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset settings: at time zero the zero deadline blocks a start
        put_sample('0, '0, '0);
        put_sample(chan_t'(7), level_t'(RSSI_MAX), '0);
        // full crossing and lap just below the time wrap; deadline wraps small
        clock_ms = 32'hFFFF_FF00;
        for (k = 0; k < 14; k++)
        begin
            put_sample(chan_t'(7), (k < 6) ? level_t'(RSSI_MAX) : level_t'(0), clock_ms);
            clock_ms += 16;
        end
        // wrapped deadline lies below now, so the lockout no longer blocks a new crossing
        put_sample(chan_t'(7), level_t'(RSSI_MAX), 32'hFFFF_FFFF);
        put_sample(chan_t'(4), 10'h2AA, 32'hAAAA_AAAA);
        put_sample(chan_t'(4), 10'h155, 32'h5555_5555);
        put_sample(chan_t'(2), level_t'(RSSI_MAX), 32'h0000_0001);
        drain_results();

        // Threshold and minimum zero through masked upper bits, no lockout;
        // channel 5 stays in one crossing long enough for the count to saturate
        write_reg(rld_pkg::REG_THRESHOLD, 16'hFC00);
        write_reg(rld_pkg::REG_LOCKOUT, 16'h0000);
        write_reg(rld_pkg::REG_MIN_COUNT, 16'hFF00);
        clock_ms = 32'h0001_0000;
        run_phase(PHASE_ITEMS, 10, 5, 5);

        // Highest settings: most crossings rejected as spikes
        write_reg(rld_pkg::REG_THRESHOLD, 16'h03FF);
        write_reg(rld_pkg::REG_LOCKOUT, 16'hFFFF);
        write_reg(rld_pkg::REG_MIN_COUNT, 16'h00FF);
        run_phase(PHASE_ITEMS, 25, 0, CHANNEL_MAX);

        // Random settings, plus a write that lands on no register
        write_reg(rld_pkg::REG_THRESHOLD, reg_data_t'($urandom()));
        write_reg(rld_pkg::REG_LOCKOUT, reg_data_t'($urandom()));
        write_reg(rld_pkg::REG_MIN_COUNT, reg_data_t'($urandom_range(0, 12)));
        write_reg(REG_UNUSED, reg_data_t'($urandom()));
        run_phase(PHASE_ITEMS, 25, 0, CHANNEL_MAX);

        // Zero minimum, long lockout, time running across the wrap
        write_reg(rld_pkg::REG_THRESHOLD, reg_data_t'($urandom_range(100, 900)));
        write_reg(rld_pkg::REG_LOCKOUT, reg_data_t'($urandom_range(20000, 65535)));
        write_reg(rld_pkg::REG_MIN_COUNT, 16'h0000);
        clock_ms = 32'hFFFF_C000;
        run_phase(PHASE_ITEMS, 25, 0, CHANNEL_MAX);

        // Reset values again, back to back with no idling
        write_reg(rld_pkg::REG_THRESHOLD, reg_data_t'(rld_pkg::THRESHOLD_RST));
        write_reg(rld_pkg::REG_LOCKOUT, reg_data_t'(rld_pkg::LOCKOUT_RST));
        write_reg(rld_pkg::REG_MIN_COUNT, reg_data_t'(rld_pkg::MIN_COUNT_RST));
        steady <= 1'b1;
        run_phase(PHASE_ITEMS, 20, 0, CHANNEL_MAX);

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog: ends the run when no transaction moves for too long
    initial
    begin : watchdog
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((sample_ch.valid && sample_ch.ready) ||
                (result_ch.valid && result_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: sim.f
hdl/rld_pkg.sv
hdl/rld_if.sv
hdl/rld_gate_logic.sv
hdl/rssi_lap_detector_top.sv
verif/rssi_lap_detector_checker.sv
verif/rssi_lap_detector_top_tb.sv
